// ----- sv/rcenc_pkg.sv -----
package rcenc_pkg;

  localparam int FREQ_BITS    = 16;
  localparam int PENDING_BITS = 32;

  localparam logic [16:0] FREQ_LIMIT   = 17'(1 << FREQ_BITS);
  localparam logic [31:0] TOP_THRES    = 32'hFF00_0000;
  localparam logic [32:0] RENORM_BOUND = 33'h0_0100_0000;
  localparam logic [32:0] FULL_RANGE   = 33'h1_0000_0000;
  localparam logic [2:0]  MAX_SHIFTS   = 3'd4;
  localparam logic [7:0]  FF_BYTE      = 8'hFF;
  localparam logic [7:0]  ZERO_BYTE    = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_ADD,
    ST_RENORM,
    ST_SHIFT,
    ST_EM_CACHE,
    ST_EM_PEND,
    ST_FL_LOW,
    ST_FINISH
  } rcenc_state_t;

  typedef struct packed {
    logic [1:0]  d;
    logic [16:0] rem;
  } rcenc_digit_t;

  // one step of floor(a * r / tot), r taken msb first; 2*rem + a < 3*tot
  function automatic rcenc_digit_t rcenc_digit(input logic [16:0] rem,
                                               input logic [16:0] a,
                                               input logic        b,
                                               input logic [16:0] tot);
    logic [18:0]  t;
    logic [18:0]  tot1;
    logic [18:0]  tot2;
    rcenc_digit_t res;
    t    = {1'b0, rem, 1'b0} + (b ? {2'b00, a} : 19'd0);
    tot1 = {2'b00, tot};
    tot2 = {1'b0, tot, 1'b0};
    if (t >= tot2) begin
      res.d   = 2'd2;
      res.rem = 17'(t - tot2);
    end else if (t >= tot1) begin
      res.d   = 2'd1;
      res.rem = 17'(t - tot1);
    end else begin
      res.d   = 2'd0;
      res.rem = 17'(t);
    end
    return res;
  endfunction

endpackage

// ----- sv/rcenc_scale_div.sv -----
module rcenc_scale_div import rcenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] r_in,
  input  logic [16:0] a_lo_in,
  input  logic [16:0] a_hi_in,
  input  logic [16:0] tot_in,
  output logic        done,
  output logic [32:0] q_lo,
  output logic [32:0] q_hi
);

  localparam int          R_BITS   = 33;
  localparam logic [5:0]  LAST_CNT = 6'(R_BITS - 1);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] r_sh;
  logic [16:0] a_lo;
  logic [16:0] a_hi;
  logic [16:0] tot;
  logic [16:0] rem_lo;
  logic [16:0] rem_hi;

  rcenc_digit_t dig_lo;
  rcenc_digit_t dig_hi;

  always_comb begin
    dig_lo = rcenc_digit(rem_lo, a_lo, r_sh[32], tot);
    dig_hi = rcenc_digit(rem_hi, a_hi, r_sh[32], tot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_sh   <= r_in;
      a_lo   <= a_lo_in;
      a_hi   <= a_hi_in;
      tot    <= tot_in;
      rem_lo <= '0;
      rem_hi <= '0;
      q_lo   <= '0;
      q_hi   <= '0;
    end else if (busy) begin
      r_sh   <= {r_sh[31:0], 1'b0};
      rem_lo <= dig_lo.rem;
      rem_hi <= dig_hi.rem;
      q_lo   <= {q_lo[31:0], 1'b0} + {31'd0, dig_lo.d};
      q_hi   <= {q_hi[31:0], 1'b0} + {31'd0, dig_hi.d};
    end
  end

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem_lo < tot) && (rem_hi < tot))
    else $error("divider remainder not below total");

endmodule

// ----- sv/range_encoder_carry_renorm.sv -----
// Byte-oriented range encoder with carry. An input item on s_* either encodes
// one symbol interval (tuser 0: cum_freq, sym_freq, tot_freq in tdata) or
// flushes the stream (tuser 1), which writes out the cached byte, the run of
// pending 0xFF bytes and the four bytes of low and then returns the coder to
// its reset state. Each result on m_* is one byte value with a repeat count;
// tlast marks the final result of an input item, and tuser flags an encode
// item whose frequencies are out of range (it is ignored and answered with a
// single zero-count result). An encode item that shifts no byte out gives no
// result. An encode item runs the 33-step bit-serial divider, which computes
// both interval bounds at once, then updates low and renormalises; a byte
// that only lengthens the pending 0xFF run passes the shift state, and one
// that releases the cache also passes the cache and pending emit states.
// Results wait in an output register, so a stalled m_tready only delays the
// coder when a result is ready while another one is already held back.
module range_encoder_carry_renorm import rcenc_pkg::*; #(
  parameter int PENDING_BITS_P = PENDING_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cum_freq[15:0], sym_freq[32:16], tot_freq[49:33]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], repeat_count[39:8]
  output logic        m_tuser,   // bad_item
  output logic        m_tlast
);

  localparam logic [PENDING_BITS_P-1:0] PENDING_MAX = '1;

  rcenc_state_t state;
  rcenc_state_t state_next;

  logic [31:0]               low_reg;
  logic                      carry_bit;
  logic [32:0]               range_reg;
  logic [7:0]                cache_byte;
  logic                      cache_valid;
  logic [PENDING_BITS_P-1:0] pending;
  logic [31:0]               lo_bound;
  logic                      flushing;
  logic [2:0]                sh_cnt;

  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic [31:0] stg_count;
  logic        stg_bad;

  logic [15:0] in_cum;
  logic [16:0] in_frq;
  logic [16:0] in_tot;
  logic        in_accept;
  logic        in_bad;
  logic [16:0] a_lo;
  logic [16:0] a_hi;

  logic        out_free;
  logic        put_ok;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [31:0] put_count;
  logic        put_bad;
  logic        push_en;
  logic        push_last;
  logic        div_start;
  logic        div_done;
  logic [32:0] q_lo;
  logic [32:0] q_hi;
  logic [32:0] add_sum;

  assign in_cum    = s_tdata[15:0];
  assign in_frq    = s_tdata[32:16];
  assign in_tot    = s_tdata[49:33];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_bad    = (in_frq == 17'd0) || (in_tot == 17'd0) || (in_tot > FREQ_LIMIT) ||
                     (({2'b00, in_cum} + {1'b0, in_frq}) > {1'b0, in_tot});
  assign a_lo      = in_tot - {1'b0, in_cum};
  assign a_hi      = a_lo - in_frq;
  assign out_free  = !m_tvalid || m_tready;
  assign put_ok    = !stg_valid || out_free;
  assign add_sum   = {1'b0, low_reg} + {1'b0, lo_bound};

  rcenc_scale_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .r_in    (range_reg),
    .a_lo_in (a_lo),
    .a_hi_in (a_hi),
    .tot_in  (in_tot),
    .done    (div_done),
    .q_lo    (q_lo),
    .q_hi    (q_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    put_en     = 1'b0;
    put_byte   = ZERO_BYTE;
    put_count  = 32'd1;
    put_bad    = 1'b0;
    push_last  = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_tuser) begin
            state_next = ST_EM_CACHE;
          end else if (in_bad) begin
            put_en     = 1'b1;
            put_count  = 32'd0;
            put_bad    = 1'b1;
            state_next = ST_FINISH;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = ST_RENORM;
      end
      ST_RENORM: begin
        if ((sh_cnt != MAX_SHIFTS) && (range_reg < RENORM_BOUND)) begin
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if ((low_reg < TOP_THRES) || carry_bit) begin
          state_next = ST_EM_CACHE;
        end else begin
          state_next = ST_RENORM;
        end
      end
      ST_EM_CACHE: begin
        put_byte  = 8'(cache_byte + {7'd0, carry_bit});
        if (!cache_valid) begin
          state_next = ST_EM_PEND;
        end else if (put_ok) begin
          put_en     = 1'b1;
          state_next = ST_EM_PEND;
        end
      end
      ST_EM_PEND: begin
        put_byte  = carry_bit ? ZERO_BYTE : FF_BYTE;
        put_count = 32'(pending);
        if ((pending == '0) || put_ok) begin
          put_en     = (pending != '0);
          state_next = flushing ? ST_FL_LOW : ST_RENORM;
        end
      end
      ST_FL_LOW: begin
        put_byte = low_reg[31:24];
        if (put_ok) begin
          put_en = 1'b1;
          if (sh_cnt == 3'd3) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        push_last = 1'b1;
        if (!stg_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign push_en = stg_valid && ((put_en && out_free) || ((state == ST_FINISH) && out_free));

  // coder state
  always_ff @(posedge clk) begin
    if (rst) begin
      low_reg     <= '0;
      carry_bit   <= 1'b0;
      range_reg   <= FULL_RANGE;
      cache_byte  <= '0;
      cache_valid <= 1'b0;
      pending     <= '0;
      flushing    <= 1'b0;
      sh_cnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          flushing <= s_tuser;
          sh_cnt   <= '0;
        end
        ST_CALC: begin
          lo_bound  <= 32'(range_reg - q_lo);
          range_reg <= q_lo - q_hi;
        end
        ST_ADD: begin
          low_reg <= add_sum[31:0];
          if (add_sum[32]) begin
            carry_bit <= 1'b1;
          end
        end
        ST_RENORM: begin
          if ((sh_cnt != MAX_SHIFTS) && (range_reg < RENORM_BOUND)) begin
            range_reg <= {range_reg[24:0], 8'h00};
          end
        end
        ST_SHIFT: begin
          if (!((low_reg < TOP_THRES) || carry_bit)) begin
            if (pending != PENDING_MAX) begin
              pending <= pending + PENDING_BITS_P'(1);
            end
            low_reg <= {low_reg[23:0], 8'h00};
            sh_cnt  <= sh_cnt + 3'd1;
          end
        end
        ST_EM_PEND: begin
          if ((pending == '0) || put_ok) begin
            if (flushing) begin
              sh_cnt <= '0;
            end else begin
              pending     <= '0;
              cache_byte  <= low_reg[31:24];
              cache_valid <= 1'b1;
              carry_bit   <= 1'b0;
              low_reg     <= {low_reg[23:0], 8'h00};
              sh_cnt      <= sh_cnt + 3'd1;
            end
          end
        end
        ST_FL_LOW: begin
          if (put_ok) begin
            sh_cnt <= sh_cnt + 3'd1;
            if (sh_cnt == 3'd3) begin
              low_reg     <= '0;
              carry_bit   <= 1'b0;
              range_reg   <= FULL_RANGE;
              cache_byte  <= '0;
              cache_valid <= 1'b0;
              pending     <= '0;
            end else begin
              low_reg <= {low_reg[23:0], 8'h00};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // one result held back until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (put_en) begin
      stg_valid <= 1'b1;
    end else if (push_en) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      stg_byte  <= put_byte;
      stg_count <= put_count;
      stg_bad   <= put_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      m_tdata <= {stg_count, stg_byte};
      m_tuser <= stg_bad;
      m_tlast <= push_last;
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !stg_valid)
    else $error("held result left over at end of item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !push_en)
    else $error("output register overwritten while stalled");

  a_range_normal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (range_reg >= RENORM_BOUND) && (range_reg <= FULL_RANGE))
    else $error("range out of normal interval between items");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
